// File: hdl/bffa_pkg.sv
`timescale 1ns / 1ps
// Shared types, field widths and codes for the bitmap first-fit allocator.
// No dependencies; imported by bitmap_first_fit_allocator_core.
package bffa_pkg;

   // Field widths of the request, response and register ports and of the bitmap words.
   localparam int CNT_W  = 14;
   localparam int STAT_W = 2;
   localparam int WORD_W = 32;
   localparam int BIT_W  = 5;

   // Command codes.
   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   // Map select codes.
   localparam logic MAP_INODE = 1'b0;
   localparam logic MAP_BLOCK = 1'b1;

   // Register indexes of the configuration port.
   localparam logic REG_INODE_COUNT = 1'b0;
   localparam logic REG_BLOCK_COUNT = 1'b1;

   // Response status codes.
   localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_RANGE = 2'd2;

   // Reset value of both count registers.
   localparam logic [CNT_W-1:0] COUNT_RESET = 14'd8192;

   // Controller states, one-hot.
   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_SCAN  = 5'b00100,
      ST_FREE  = 5'b01000,
      ST_RESP  = 5'b10000
   } state_type;

   // Position of the lowest clear bit of a word; only meaningful when one exists.
   function automatic logic [BIT_W-1:0] first_clear(input logic [WORD_W-1:0] word);
      logic [BIT_W-1:0] pos;
      pos = '0;
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (!word[i]) begin
            pos = BIT_W'(i);
         end
      end
      return pos;
   endfunction

endpackage

// File: hdl/bitmap_first_fit_allocator_core.sv
`timescale 1ns / 1ps
// Bitmap first-fit allocator: both bitmaps in one word memory, scan and update controller.
// Depends on bffa_pkg for widths, codes and the state type.
//
// Usage
// The request channel (req_valid, req_stall) carries a command, a map select and an entry
// number. An allocate request reads the chosen bitmap one 32-bit word per cycle from word 0
// up to the word holding the last bit in use, sets the first clear bit and answers with its
// one-based number. A free request reads one word and clears the named bit. The response
// channel (rsp_valid, rsp_stall) returns the allocated number, a status and the free count
// of the chosen map after the request.
// An allocate reads bitmap words until one with a clear bit is found, at most ceil(count / 32)
// of them; a free reads one word before its update, and a free out of range or an allocate
// with a count of zero goes straight to the response. The word scan, one memory read per
// cycle, sets the allocate time; one request is in work at a time, so the next is taken in
// the cycle after the previous response is loaded.
// The response sits in an output register: a new request may be taken while it waits, and
// a stalled response holds until rsp_stall falls, the next result waiting behind it.
// After reset the memory is swept to zero, one word per cycle, over all of its words (512
// with the default size); requests are stalled meanwhile while register writes on the csr_
// port are taken at any time.
module bitmap_first_fit_allocator_core #(
   parameter int MAP_BITS = 8192
) (
   input  logic                            clock,
   input  logic                            reset,
   // Register write port
   input  logic                            csr_we,
   input  logic                            csr_index,
   input  logic [bffa_pkg::CNT_W-1:0]      csr_wdata,
   // Request channel
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_command,
   input  logic                            req_which_map,
   input  logic [bffa_pkg::CNT_W-1:0]      req_entry_number,
   // Response channel
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [bffa_pkg::CNT_W-1:0]      rsp_allocated_number,
   output logic [bffa_pkg::STAT_W-1:0]     rsp_status,
   output logic [bffa_pkg::CNT_W-1:0]      rsp_free_count
);
   import bffa_pkg::*;

   localparam int MAP_WORDS = (MAP_BITS + WORD_W - 1) / WORD_W;
   localparam int WA_W      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int IDX_W     = WA_W + BIT_W;
   localparam int MA_W      = WA_W + 1;
   localparam int DEPTH     = 2 ** MA_W;

   // Controller and bookkeeping registers.
   state_type               state_ff, state_in;
   logic [MA_W-1:0]         clr_ff, clr_in;
   logic [CNT_W-1:0]        inode_count_ff, inode_count_in;
   logic [CNT_W-1:0]        block_count_ff, block_count_in;
   logic [CNT_W-1:0]        inode_used_ff, inode_used_in;
   logic [CNT_W-1:0]        block_used_ff, block_used_in;
   logic                    map_ff, map_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [WA_W-1:0]         scan_ff, scan_in;
   logic [WA_W-1:0]         last_word_ff, last_word_in;
   logic [BIT_W-1:0]        tail_ff, tail_in;
   logic [BIT_W-1:0]        bit_ff, bit_in;
   logic [WA_W-1:0]         word_ff, word_in;
   logic [CNT_W-1:0]        res_alloc_ff, res_alloc_in;
   logic [STAT_W-1:0]       res_status_ff, res_status_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0]        rsp_alloc_ff, rsp_alloc_in;
   logic [STAT_W-1:0]       rsp_status_ff, rsp_status_in;
   logic [CNT_W-1:0]        rsp_free_ff, rsp_free_in;

   // Memory and its access signals.
   logic [WORD_W-1:0]       mem [DEPTH];
   logic [WORD_W-1:0]       rd_data_ff;
   logic [MA_W-1:0]         mem_raddr;
   logic                    mem_we;
   logic [MA_W-1:0]         mem_waddr;
   logic [WORD_W-1:0]       mem_wdata;

   // Request-side decode.
   logic                    req_accept;
   logic [CNT_W-1:0]        req_count_raw;
   logic [CNT_W-1:0]        req_count;
   logic [IDX_W-1:0]        req_last_idx;
   logic [IDX_W-1:0]        req_entry_idx;
   logic                    req_out_of_range;

   // Scan and result helpers.
   logic [WORD_W-1:0]       tail_mask;
   logic [WORD_W-1:0]       word_view;
   logic                    scan_found;
   logic [BIT_W-1:0]        scan_bit;
   logic [WORD_W-1:0]       bit_onehot;
   logic [CNT_W-1:0]        used_sel;
   logic                    rsp_load;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;

   // Effective count of the requested map, clamped to the bitmap size.
   always_comb begin
      req_count_raw = (req_which_map == MAP_BLOCK) ? block_count_ff : inode_count_ff;
      if (32'(req_count_raw) > 32'(MAP_BITS)) begin
         req_count = CNT_W'(MAP_BITS);
      end else begin
         req_count = req_count_raw;
      end
      req_last_idx     = IDX_W'(req_count - 14'd1);
      req_entry_idx    = IDX_W'(req_entry_number - 14'd1);
      req_out_of_range = (req_entry_number == '0) || (req_entry_number > req_count);
   end

   // Lowest clear bit of the word under scan; bits past the count read as taken.
   always_comb begin
      if ((scan_ff == last_word_ff) && (tail_ff != '0)) begin
         tail_mask = ~((32'd1 << tail_ff) - 32'd1);
      end else begin
         tail_mask = '0;
      end
      word_view  = rd_data_ff | tail_mask;
      scan_found = (word_view != '1);
      scan_bit   = first_clear(word_view);
      bit_onehot = 32'd1 << bit_ff;
      used_sel   = (map_ff == MAP_BLOCK) ? block_used_ff : inode_used_ff;
      rsp_load   = (state_ff == ST_RESP) && (!rsp_valid_ff || !rsp_stall);
   end

   // Register writes.
   always_comb begin
      inode_count_in = inode_count_ff;
      block_count_in = block_count_ff;
      if (csr_we) begin
         case (csr_index)
            REG_INODE_COUNT: inode_count_in = csr_wdata;
            REG_BLOCK_COUNT: block_count_in = csr_wdata;
            default:         inode_count_in = inode_count_ff;
         endcase
      end
   end

   // Main controller: clearing pass, request decode, word scan, free update, response.
   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      inode_used_in = inode_used_ff;
      block_used_in = block_used_ff;
      map_in        = map_ff;
      count_in      = count_ff;
      scan_in       = scan_ff;
      last_word_in  = last_word_ff;
      tail_in       = tail_ff;
      bit_in        = bit_ff;
      word_in       = word_ff;
      res_alloc_in  = res_alloc_ff;
      res_status_in = res_status_ff;
      mem_raddr     = {map_ff, scan_ff};
      mem_we        = 1'b0;
      mem_waddr     = {map_ff, word_ff};
      mem_wdata     = '0;

      case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            if (req_accept) begin
               map_in        = req_which_map;
               count_in      = req_count;
               last_word_in  = req_last_idx[IDX_W-1:BIT_W];
               tail_in       = req_count[BIT_W-1:0];
               bit_in        = req_entry_idx[BIT_W-1:0];
               word_in       = req_entry_idx[IDX_W-1:BIT_W];
               scan_in       = '0;
               res_alloc_in  = '0;
               res_status_in = STATUS_OK;
               if (req_command == CMD_ALLOC) begin
                  mem_raddr = {req_which_map, {WA_W{1'b0}}};
                  if (req_count == '0) begin
                     res_status_in = STATUS_FULL;
                     state_in      = ST_RESP;
                  end else begin
                     state_in = ST_SCAN;
                  end
               end else begin
                  mem_raddr = {req_which_map, req_entry_idx[IDX_W-1:BIT_W]};
                  if (req_out_of_range) begin
                     res_status_in = STATUS_RANGE;
                     state_in      = ST_RESP;
                  end else begin
                     state_in = ST_FREE;
                  end
               end
            end
         end

         ST_SCAN: begin
            // The next word is read ahead; it is dropped when this one has a clear bit.
            mem_raddr = {map_ff, scan_ff + 1'b1};
            if (scan_found) begin
               mem_we       = 1'b1;
               mem_waddr    = {map_ff, scan_ff};
               mem_wdata    = rd_data_ff | (32'd1 << scan_bit);
               res_alloc_in = CNT_W'({scan_ff, scan_bit}) + 14'd1;
               if (map_ff == MAP_BLOCK) begin
                  block_used_in = block_used_ff + 14'd1;
               end else begin
                  inode_used_in = inode_used_ff + 14'd1;
               end
               state_in = ST_RESP;
            end else if (scan_ff == last_word_ff) begin
               res_status_in = STATUS_FULL;
               state_in      = ST_RESP;
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end

         ST_FREE: begin
            // Only a bit that is set changes the map and the used counter.
            if ((rd_data_ff & bit_onehot) != '0) begin
               mem_we    = 1'b1;
               mem_wdata = rd_data_ff & ~bit_onehot;
               if (map_ff == MAP_BLOCK) begin
                  if (block_used_ff != '0) begin
                     block_used_in = block_used_ff - 14'd1;
                  end
               end else begin
                  if (inode_used_ff != '0) begin
                     inode_used_in = inode_used_ff - 14'd1;
                  end
               end
            end
            state_in = ST_RESP;
         end

         ST_RESP: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output register: loaded from the finished request, held while stalled.
   always_comb begin
      rsp_alloc_in  = rsp_alloc_ff;
      rsp_status_in = rsp_status_ff;
      rsp_free_in   = rsp_free_ff;
      if (rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_alloc_in  = res_alloc_ff;
         rsp_status_in = res_status_ff;
         rsp_free_in   = (count_ff > used_sel) ? (count_ff - used_sel) : '0;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         clr_ff         <= '0;
         inode_count_ff <= COUNT_RESET;
         block_count_ff <= COUNT_RESET;
         inode_used_ff  <= '0;
         block_used_ff  <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         clr_ff         <= clr_in;
         inode_count_ff <= inode_count_in;
         block_count_ff <= block_count_in;
         inode_used_ff  <= inode_used_in;
         block_used_ff  <= block_used_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      map_ff        <= map_in;
      count_ff      <= count_in;
      scan_ff       <= scan_in;
      last_word_ff  <= last_word_in;
      tail_ff       <= tail_in;
      bit_ff        <= bit_in;
      word_ff       <= word_in;
      res_alloc_ff  <= res_alloc_in;
      res_status_ff <= res_status_in;
      rsp_alloc_ff  <= rsp_alloc_in;
      rsp_status_ff <= rsp_status_in;
      rsp_free_ff   <= rsp_free_in;
   end

   // Bitmap memory: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[mem_raddr];
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_allocated_number = rsp_alloc_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_free_count       = rsp_free_ff;

   // A fresh response only ever follows the response state.
   a_rsp_from_resp : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_RESP))
      else $error("response raised outside the response state");

   // A failed request never reports an allocated number.
   a_fail_no_number : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff != STATUS_OK) |-> (rsp_alloc_ff == '0))
      else $error("failed request reports an allocated number");

   // The scan never runs past the word that holds the last bit in use.
   a_scan_bound : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (scan_ff <= last_word_ff))
      else $error("scan beyond the last word in use");

   // Used counters move only on a found allocate or on a free.
   a_used_change : assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && (!$stable(inode_used_ff) || !$stable(block_used_ff))
      |-> $past(state_ff == ST_SCAN || state_ff == ST_FREE))
      else $error("used counter changed outside an update");

   // The map is not written while a request may be taken.
   a_no_write_idle : assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff != ST_IDLE) && (state_ff != ST_RESP))
      else $error("bitmap written while idle");

endmodule
